// File: design/hsv_saturation_adjust_defines.svh
// assertion macros for the checker file of hsv_saturation_adjust
// no dependencies; clk and rst_n must be visible where a macro is used
`ifndef HSV_SATURATION_ADJUST_DEFINES_SVH
`define HSV_SATURATION_ADJUST_DEFINES_SVH

// implication checked in the next cycle, off during reset
`define HSVSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// invariant checked at every edge, off during reset
`define HSVSA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication that also holds while reset is applied
`define HSVSA_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hsvsa_pkg.sv
// shared types and constants for the hsv saturation adjust pipeline
// no dependencies
package hsvsa_pkg;

  localparam int unsigned RECIP_W = 25;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // hue sector codes
  localparam logic [2:0] SECT_0 = 3'd0;
  localparam logic [2:0] SECT_1 = 3'd1;
  localparam logic [2:0] SECT_2 = 3'd2;
  localparam logic [2:0] SECT_3 = 3'd3;
  localparam logic [2:0] SECT_4 = 3'd4;

  // hsv form of one pixel between the front and back halves
  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] frac;
    logic [16:0] sat;
    logic [7:0]  val;
    logic        gray;
    logic        last;
  } hsv_t;

endpackage

// File: design/hsv_saturation_adjust.sv
// channel   | dir | signals                                   | content
// in        | in  | in_tvalid in_tready in_tdata in_tlast     | rgb888 pixel, frame end
// out       | out | out_tvalid out_tready out_tdata out_tlast | adjusted pixel, frame end
// cfg       | in  | cfg_we cfg_wdata                          | saturation gain, q8.8
//
// one pixel per clock sustained while out_tready is high; eight register stages
// (four for rgb to hsv, four for gain and rebuild), set by the multiply and correct steps
// each stage holds its beat while the next is full, so stalls lose and repeat nothing
// synchronous active-low reset empties the pipeline and sets the gain to unity (256)
//
// top level: gain register, rgb to hsv front, gain and rebuild back
// depends on hsvsa_pkg, hsvsa_front, hsvsa_back
module hsv_saturation_adjust (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  input  logic        in_tlast,   // frame_end_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_out, green_out, blue_out
  output logic        out_tlast,  // frame_end_out
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata   // sat_gain
);
  import hsvsa_pkg::*;

  logic [15:0] sat_gain_r;
  logic        mid_valid, mid_ready;
  hsv_t        mid_hsv;

  // saturation gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_gain_r <= 16'd256;
    end else if (cfg_we) begin
      sat_gain_r <= cfg_wdata;
    end
  end

  hsvsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .last      (in_tlast),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_hsv   (mid_hsv)
  );

  hsvsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (sat_gain_r),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_hsv    (mid_hsv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (out_tdata[7:0]),
    .green     (out_tdata[15:8]),
    .blue      (out_tdata[23:16]),
    .last      (out_tlast)
  );

endmodule

// File: design/hsvsa_front.sv
// rgb to hsv conversion, four register stages
// depends on hsvsa_pkg
module hsvsa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvsa_pkg::hsv_t   out_hsv
);
  import hsvsa_pkg::*;

  // reciprocal table, ceil(2^24 / d), zero for d = 0
  logic [RECIP_W-1:0] recip_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_recip
    localparam logic [31:0] RV = ((32'd1 << 24) + gi - 1) / ((gi == 0) ? 1 : gi);
    assign recip_tab[gi] = (gi == 0) ? '0 : RV[RECIP_W-1:0];
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !v4_r || out_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // stage 1: max, delta and hue position in units of delta
  logic [7:0]  mx_c, mn_c, dl_c;
  logic [11:0] d12, tot_c;
  logic [7:0]  mx1_r, d1_r;
  logic [10:0] tot1_r;
  logic        fe1_r;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c)  mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c)  mn_c = blue;
    dl_c = mx_c - mn_c;
    d12  = {4'b0, dl_c};
    if (red == mx_c) begin
      tot_c = {4'b0, green} - {4'b0, blue};
    end else if (green == mx_c) begin
      tot_c = (d12 << 1) + {4'b0, blue} - {4'b0, red};
    end else begin
      tot_c = (d12 << 2) + {4'b0, red} - {4'b0, green};
    end
    if (tot_c[11]) tot_c = tot_c + (d12 << 2) + (d12 << 1);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mx1_r  <= mx_c;
      d1_r   <= dl_c;
      tot1_r <= tot_c[10:0];
      fe1_r  <= last;
    end
  end

  // stage 2: saturation estimate, sector and remainder
  logic [32:0]        sp_c;
  logic [10:0]        dk [1:5];
  logic [2:0]         sec_c;
  logic [10:0]        rem_c;
  logic [16:0]        sest2_r;
  logic [2:0]         sec2_r;
  logic [7:0]         rem2_r, mx2_r, d2_r;
  logic [RECIP_W-1:0] recd2_r;
  logic               fe2_r;

  always_comb begin
    sp_c = 33'(d1_r) * 33'(recip_tab[mx1_r]);
    for (int k = 1; k <= 5; k++) dk[k] = 11'(d1_r) * 11'(k);
    sec_c = 3'd0;
    rem_c = tot1_r;
    for (int k = 1; k <= 5; k++) begin
      if (tot1_r >= dk[k]) begin
        sec_c = 3'(k);
        rem_c = tot1_r - dk[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      sest2_r <= sp_c[24:8];
      sec2_r  <= sec_c;
      rem2_r  <= rem_c[7:0];
      recd2_r <= recip_tab[d1_r];
      mx2_r   <= mx1_r;
      d2_r    <= d1_r;
      fe2_r   <= fe1_r;
    end
  end

  // stage 3: correct saturation, estimate hue fraction
  logic [24:0] chk_s_c;
  logic [32:0] fp_c;
  logic [16:0] sat3_r, fest3_r;
  logic [2:0]  sec3_r;
  logic [7:0]  rem3_r, mx3_r, d3_r;
  logic        fe3_r;

  assign chk_s_c = 25'(sest2_r) * 25'(mx2_r);
  assign fp_c    = 33'(rem2_r) * 33'(recd2_r);

  always_ff @(posedge clk) begin
    if (adv3) begin
      sat3_r  <= (chk_s_c > {1'b0, d2_r, 16'b0}) ? sest2_r - 17'd1 : sest2_r;
      fest3_r <= fp_c[24:8];
      sec3_r  <= sec2_r;
      rem3_r  <= rem2_r;
      mx3_r   <= mx2_r;
      d3_r    <= d2_r;
      fe3_r   <= fe2_r;
    end
  end

  // stage 4: correct hue fraction
  logic [24:0] chk_f_c;
  logic [16:0] frac_c;

  assign chk_f_c = 25'(fest3_r) * 25'(d3_r);
  assign frac_c  = (chk_f_c > {1'b0, rem3_r, 16'b0}) ? fest3_r - 17'd1 : fest3_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_hsv.sector <= sec3_r;
      out_hsv.frac   <= frac_c[15:0];
      out_hsv.sat    <= sat3_r;
      out_hsv.val    <= mx3_r;
      out_hsv.gray   <= (d3_r == 8'd0);
      out_hsv.last   <= fe3_r;
    end
  end

endmodule

// File: design/hsvsa_back.sv
// saturation gain and hsv to rgb rebuild, four register stages
// depends on hsvsa_pkg
module hsvsa_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       gain,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvsa_pkg::hsv_t   in_hsv,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              last
);
  import hsvsa_pkg::*;

  logic v5_r, v6_r, v7_r, v8_r;
  logic adv5, adv6, adv7, adv8;

  assign adv8      = !v8_r || out_ready;
  assign adv7      = !v7_r || adv8;
  assign adv6      = !v6_r || adv7;
  assign adv5      = !v5_r || adv6;
  assign in_ready  = adv5;
  assign out_valid = v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (adv5) v5_r <= in_valid;
      if (adv6) v6_r <= v5_r;
      if (adv7) v7_r <= v6_r;
      if (adv8) v8_r <= v7_r;
    end
  end

  // stage 5: scaled saturation, clamped to one
  logic [32:0] gp_c;
  logic [16:0] s25_r;
  logic [15:0] fr5_r;
  logic [2:0]  sec5_r;
  logic [7:0]  v5v_r;
  logic        gr5_r, fe5_r;

  assign gp_c = 33'(in_hsv.sat) * 33'(gain);

  always_ff @(posedge clk) begin
    if (adv5) begin
      s25_r  <= (gp_c[32:8] > 25'(ONE_Q16)) ? ONE_Q16 : gp_c[24:8];
      fr5_r  <= in_hsv.frac;
      sec5_r <= in_hsv.sector;
      v5v_r  <= in_hsv.val;
      gr5_r  <= in_hsv.gray;
      fe5_r  <= in_hsv.last;
    end
  end

  // stage 6: fraction products for q and t
  logic [33:0] aq_c, at_c;
  logic [16:0] aq6_r, at6_r, kp6_r;
  logic [2:0]  sec6_r;
  logic [7:0]  v6v_r;
  logic        gr6_r, fe6_r;

  assign aq_c = 34'(s25_r) * 34'(fr5_r);
  assign at_c = 34'(s25_r) * 34'(ONE_Q16 - 17'(fr5_r));

  always_ff @(posedge clk) begin
    if (adv6) begin
      aq6_r  <= aq_c[32:16];
      at6_r  <= at_c[32:16];
      kp6_r  <= ONE_Q16 - s25_r;
      sec6_r <= sec5_r;
      v6v_r  <= v5v_r;
      gr6_r  <= gr5_r || (s25_r == 17'd0);
      fe6_r  <= fe5_r;
    end
  end

  // stage 7: p, q and t from value
  logic [24:0] pp_c, pq_c, pt_c;
  logic [7:0]  p7_r, q7_r, t7_r, v7v_r;
  logic [2:0]  sec7_r;
  logic        gr7_r, fe7_r;

  assign pp_c = 25'(v6v_r) * 25'(kp6_r);
  assign pq_c = 25'(v6v_r) * 25'(ONE_Q16 - aq6_r);
  assign pt_c = 25'(v6v_r) * 25'(ONE_Q16 - at6_r);

  always_ff @(posedge clk) begin
    if (adv7) begin
      p7_r   <= pp_c[23:16];
      q7_r   <= pq_c[23:16];
      t7_r   <= pt_c[23:16];
      v7v_r  <= v6v_r;
      sec7_r <= sec6_r;
      gr7_r  <= gr6_r;
      fe7_r  <= fe6_r;
    end
  end

  // stage 8: sector table into the output register
  logic [7:0] r_c, g_c, b_c;

  always_comb begin
    case (sec7_r)
      SECT_0:  begin r_c = v7v_r; g_c = t7_r;  b_c = p7_r;  end
      SECT_1:  begin r_c = q7_r;  g_c = v7v_r; b_c = p7_r;  end
      SECT_2:  begin r_c = p7_r;  g_c = v7v_r; b_c = t7_r;  end
      SECT_3:  begin r_c = p7_r;  g_c = q7_r;  b_c = v7v_r; end
      SECT_4:  begin r_c = t7_r;  g_c = p7_r;  b_c = v7v_r; end
      default: begin r_c = v7v_r; g_c = p7_r;  b_c = q7_r;  end
    endcase
    if (gr7_r) begin
      r_c = v7v_r;
      g_c = v7v_r;
      b_c = v7v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv8) begin
      red   <= r_c;
      green <= g_c;
      blue  <= b_c;
      last  <= fe7_r;
    end
  end

endmodule

// File: design/hsvsa_checker.sv
// port-level checks for hsv_saturation_adjust, bound to the top level
// depends on hsv_saturation_adjust_defines.svh
`include "hsv_saturation_adjust_defines.svh"

module hsvsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  logic [3:0] occ_r;

  // beats accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 4'd0;
    end else begin
      occ_r <= occ_r + 4'(in_tvalid && in_tready) - 4'(out_tvalid && out_tready);
    end
  end

  `HSVSA_ASSERT_RESET(a_reset_empty, !rst_n, !out_tvalid, "output valid right after reset")
  `HSVSA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output beat changed")
  `HSVSA_ASSERT_ALWAYS(a_occupancy, (occ_r <= 4'd8) && (!out_tvalid || occ_r != 4'd0), "beat count out of range")

endmodule

bind hsv_saturation_adjust hsvsa_checker u_hsvsa_checker (.*);
